### rtl/core/alcr_pkg.sv
// Shared types and constants of the arc-length Catmull-Rom resampler.
package alcr_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int MAX_OUTPUTS = 64;

    localparam logic [6:0] OUTPUT_COUNT_RESET = 7'd16;
    localparam logic [6:0] OUTPUT_COUNT_MIN   = 7'd2;
    localparam logic [6:0] OUTPUT_COUNT_MAX   = 7'(MAX_OUTPUTS);

    // Register index, taken from paddr[2].
    localparam logic REG_OUTPUT_COUNT = 1'b0;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_ABS,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_ROOT,
        S_STORE,
        S_LASTCHK,
        S_PUT0,
        S_TDIV,
        S_SRD,
        S_SCMP,
        S_FETCH,
        S_TSETUP,
        S_DDIV,
        S_COEF,
        S_MUL,
        S_ACC,
        S_SAT,
        S_PUT
    } t_state;

endpackage

### rtl/core/arc_length_catmull_rom_resampler_core.sv
// Top level of the arc-length Catmull-Rom resampler: sequencer, shared units and point store.

// Points are taken one per transfer while o_stall is low. A point that is dropped (a
// duplicate of the last kept point, or one beyond the 256-entry store) writes nothing to the store;
// a point that opens a new segment runs the 32-step bitwise square root of its segment
// length. The transfer with i_last_point high then starts the run: the first result is
// (0,0), and each further result uses the two 64-step restoring divisions (target
// length and local parameter) and the multiplier that is shared by the six Horner steps
// of x and y. The output register lets the next result be computed while the previous
// one waits to be taken. The store needs no clearing after reset. output_count sits at
// byte address 0 of the APB port.
module arc_length_catmull_rom_resampler_core
    import alcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Point channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_last_point,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_final_result,
    output logic [1:0]         o_status,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_state r_state, n_state;

    // Latched input point.
    logic signed [31:0] r_px, r_py;
    logic               r_last;

    // Gesture store bookkeeping.
    logic [ADDR_W:0]    r_kc;
    logic               r_ovf;
    logic signed [31:0] r_lx, r_ly;
    logic [47:0]        r_lcum;

    // Segment length datapath.
    logic [30:0]        r_ax, r_ay;
    logic               r_sh;
    logic [63:0]        r_acc, r_res, r_bit;
    logic [5:0]         r_cnt;

    // Shared multiplier and divider.
    logic signed [71:0] r_prod;
    logic [47:0]        r_rem, r_dvs;
    logic [63:0]        r_quo;

    // Run state.
    logic [ADDR_W:0]    r_k;
    logic [1:0]         r_st;
    logic               r_emp;
    logic [6:0]         r_n;
    logic [5:0]         r_i;
    logic [53:0]        r_itot;
    logic [47:0]        r_tgt;
    logic [ADDR_W-1:0]  r_j;
    logic [2:0]         r_fc;
    logic signed [31:0] r_qx [0:3];
    logic signed [31:0] r_qy [0:3];
    logic [47:0]        r_c0, r_c1;
    logic [16:0]        r_t;
    logic               r_cy;
    logic [1:0]         r_hs;
    logic signed [39:0] r_h;
    logic signed [31:0] r_rx, r_ry;

    // Output register and configuration.
    logic               r_ov, r_ofin;
    logic signed [31:0] r_ox, r_oy;
    logic [1:0]         r_ost;
    logic [6:0]         r_outcnt;

    // Point store.
    logic signed [31:0] mem_x [0:MAX_POINTS-1];
    logic signed [31:0] mem_y [0:MAX_POINTS-1];
    logic [47:0]        mem_c [0:MAX_POINTS-1];
    logic signed [31:0] rd_x, rd_y;
    logic [47:0]        rd_c;

    // Control decoded from the state.
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic [47:0]        w_wc;
    logic signed [39:0] w_ma;
    logic signed [31:0] w_mb;

    // Combinational helpers.
    logic               in_xfer, out_free, cfg_wr;
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic               w_sh;
    logic [63:0]        root_try;
    logic [32:0]        seg_len;
    logic [48:0]        div_trial;
    logic               div_ge;
    logic [47:0]        div_rem_n;
    logic [63:0]        div_quo_n;
    logic [ADDR_W-1:0]  idx0, idx3;
    logic               srch_more;
    logic [47:0]        seg_w, rem_w;
    logic signed [39:0] ca, cb, cc, cd, coef1, coef2, coef3, addend;
    logic signed [39:0] h_half;
    logic signed [31:0] h_sat;
    logic [6:0]         n_clamped;
    logic               last_pos;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_COUNT);

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ov;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_final_result = r_ofin;
    assign o_status       = r_ost;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == REG_OUTPUT_COUNT) ? {25'd0, r_outcnt} : 32'd0;

    // Absolute coordinate differences and the pre-shift for very long segments.
    always_comb begin
        dx   = 33'(r_px) - 33'(r_lx);
        dy   = 33'(r_py) - 33'(r_ly);
        adx  = dx[32] ? 33'(-dx) : 33'(dx);
        ady  = dy[32] ? 33'(-dy) : 33'(dy);
        w_sh = adx[32] | adx[31] | ady[32] | ady[31];
    end

    // Square root step, divider step and segment length.
    always_comb begin
        root_try  = r_res + r_bit;
        seg_len   = {1'b0, r_res[31:0]} << r_sh;
        div_trial = {r_rem, r_quo[63]};
        div_ge    = div_trial >= {1'b0, r_dvs};
        div_rem_n = div_ge ? 48'(div_trial - {1'b0, r_dvs}) : div_trial[47:0];
        div_quo_n = {r_quo[62:0], div_ge};
    end

    // Neighbour indices with the end points clamped, and the search limit.
    always_comb begin
        idx0      = (r_j == '0) ? '0 : r_j - 1'b1;
        idx3      = (({1'b0, r_j} + 2'd2) < r_k) ? ADDR_W'(r_j + 2'd2)
                                                 : ADDR_W'(r_k - 1'b1);
        srch_more = (({1'b0, r_j} + 1'b1) < (r_k - 1'b1));
        seg_w     = r_c1 - r_c0;
        rem_w     = (r_tgt - r_c0 > seg_w) ? seg_w : r_tgt - r_c0;
        n_clamped = (r_outcnt < OUTPUT_COUNT_MIN) ? OUTPUT_COUNT_MIN :
                    (r_outcnt > OUTPUT_COUNT_MAX) ? OUTPUT_COUNT_MAX : r_outcnt;
        last_pos  = ({1'b0, r_i} == (r_n - 1'b1));
    end

    // Spline coefficients of the coordinate in work.
    always_comb begin
        ca     = r_cy ? 40'(r_qy[0]) : 40'(r_qx[0]);
        cb     = r_cy ? 40'(r_qy[1]) : 40'(r_qx[1]);
        cc     = r_cy ? 40'(r_qy[2]) : 40'(r_qx[2]);
        cd     = r_cy ? 40'(r_qy[3]) : 40'(r_qx[3]);
        coef1  = cc - ca;
        coef2  = (ca <<< 1) - (cb <<< 2) - cb + (cc <<< 2) - cd;
        coef3  = (cb <<< 1) + cb - (cc <<< 1) - cc + cd - ca;
        addend = (r_hs == 2'd0) ? coef2 : (r_hs == 2'd1) ? coef1 : (cb <<< 1);
        h_half = r_h >>> 1;
        if (h_half > 40'sd2147483647) begin
            h_sat = 32'sh7FFFFFFF;
        end else if (h_half < -40'sd2147483648) begin
            h_sat = 32'sh80000000;
        end else begin
            h_sat = h_half[31:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_LOAD;
            end
            S_LOAD: begin
                priority if (r_kc == '0) n_state = S_LASTCHK;
                else if (r_px == r_lx && r_py == r_ly) n_state = S_LASTCHK;
                else if (r_kc[ADDR_W]) n_state = S_LASTCHK;
                else n_state = S_ABS;
            end
            S_ABS:     n_state = S_SQ1;
            S_SQ1:     n_state = S_SQ2;
            S_SQ2:     n_state = S_SQ3;
            S_SQ3:     n_state = S_ROOT;
            S_ROOT: begin
                if (r_cnt == 6'd31) n_state = S_STORE;
            end
            S_STORE:   n_state = S_LASTCHK;
            S_LASTCHK: n_state = r_last ? S_PUT0 : S_IDLE;
            S_PUT0: begin
                if (out_free) n_state = r_emp ? S_IDLE : S_TDIV;
            end
            S_TDIV: begin
                if (r_cnt == 6'd63) n_state = S_SRD;
            end
            S_SRD:     n_state = srch_more ? S_SCMP : S_FETCH;
            S_SCMP:    n_state = (rd_c <= r_tgt) ? S_SRD : S_FETCH;
            S_FETCH: begin
                if (r_fc == 3'd4) n_state = S_TSETUP;
            end
            S_TSETUP:  n_state = (seg_w == '0) ? S_COEF : S_DDIV;
            S_DDIV: begin
                if (r_cnt == 6'd63) n_state = S_COEF;
            end
            S_COEF:    n_state = S_MUL;
            S_MUL:     n_state = S_ACC;
            S_ACC:     n_state = (r_hs == 2'd2) ? S_SAT : S_MUL;
            S_SAT:     n_state = r_cy ? S_PUT : S_COEF;
            S_PUT: begin
                if (out_free) n_state = last_pos ? S_IDLE : S_TDIV;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Store port and multiplier operands.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_kc[ADDR_W-1:0];
        w_wc    = r_lcum + 48'(seg_len);
        w_raddr = r_j;
        w_ma    = 40'(r_h);
        w_mb    = 32'(r_t);
        unique case (r_state)
            S_LOAD: begin
                if (r_kc == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wc    = '0;
                end
            end
            S_STORE: w_we = 1'b1;
            S_SQ1: begin
                w_ma = 40'(r_ax);
                w_mb = 32'(r_ax);
            end
            S_SQ2: begin
                w_ma = 40'(r_ay);
                w_mb = 32'(r_ay);
            end
            S_SRD: w_raddr = ADDR_W'(r_j + 1'b1);
            S_FETCH: begin
                unique case (r_fc)
                    3'd0:    w_raddr = idx0;
                    3'd1:    w_raddr = r_j;
                    3'd2:    w_raddr = ADDR_W'(r_j + 1'b1);
                    default: w_raddr = idx3;
                endcase
            end
            default: ;
        endcase
    end

    // Point store, written and read in one clocked block.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[w_waddr] <= r_px;
            mem_y[w_waddr] <= r_py;
            mem_c[w_waddr] <= w_wc;
        end
        rd_x <= mem_x[w_raddr];
        rd_y <= mem_y[w_raddr];
        rd_c <= mem_c[w_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kc     <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
            r_outcnt <= OUTPUT_COUNT_RESET;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_outcnt <= pwdata[6:0];
            // The output register fills when a result is placed and empties on its transfer.
            if ((r_state == S_PUT0 || r_state == S_PUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (r_kc == '0) begin
                        r_kc <= (ADDR_W+1)'(1);
                    end else if ((r_px != r_lx || r_py != r_ly) && r_kc[ADDR_W]) begin
                        r_ovf <= 1'b1;
                    end
                end
                S_STORE: r_kc <= r_kc + 1'b1;
                S_LASTCHK: begin
                    if (r_last) begin
                        r_kc  <= '0;
                        r_ovf <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_px   <= i_point_x;
                    r_py   <= i_point_y;
                    r_last <= i_last_point;
                end
            end
            S_LOAD: begin
                if (r_kc == '0) begin
                    r_lx   <= r_px;
                    r_ly   <= r_py;
                    r_lcum <= '0;
                end
            end
            S_ABS: begin
                r_sh <= w_sh;
                r_ax <= w_sh ? adx[31:1] : adx[30:0];
                r_ay <= w_sh ? ady[31:1] : ady[30:0];
            end
            S_SQ2: r_acc <= r_prod[63:0];
            S_SQ3: begin
                r_acc <= r_acc + r_prod[63:0];
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            S_ROOT: begin
                if (r_acc >= root_try) begin
                    r_acc <= r_acc - root_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            S_STORE: begin
                r_lx   <= r_px;
                r_ly   <= r_py;
                r_lcum <= w_wc;
            end
            S_LASTCHK: begin
                r_k    <= r_kc;
                r_st   <= r_ovf ? STATUS_DROPPED : STATUS_OK;
                r_emp  <= (r_kc < 2'd2) || (r_lcum == '0);
                r_n    <= n_clamped;
                r_i    <= 6'd1;
                r_itot <= 54'(r_lcum);
                r_j    <= '0;
            end
            S_PUT0: begin
                if (out_free) begin
                    r_ox   <= '0;
                    r_oy   <= '0;
                    r_ofin <= r_emp;
                    r_ost  <= r_emp ? STATUS_EMPTY : r_st;
                    // Start the division for the first target length.
                    r_rem  <= '0;
                    r_quo  <= 64'(r_itot);
                    r_dvs  <= 48'(r_n - 1'b1);
                    r_cnt  <= '0;
                end
            end
            S_TDIV, S_DDIV: begin
                r_rem <= div_rem_n;
                r_quo <= div_quo_n;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    if (r_state == S_TDIV) r_tgt <= div_quo_n[47:0];
                    else r_t <= div_quo_n[16:0];
                end
                r_fc <= '0;
                r_cy <= 1'b0;
            end
            S_SRD: r_fc <= '0;
            S_SCMP: begin
                r_fc <= '0;
                if (rd_c <= r_tgt) r_j <= r_j + 1'b1;
            end
            S_FETCH: begin
                r_fc <= r_fc + 1'b1;
                if (r_fc != 3'd0) begin
                    r_qx[2'(r_fc - 1'b1)] <= rd_x;
                    r_qy[2'(r_fc - 1'b1)] <= rd_y;
                end
                if (r_fc == 3'd2) r_c0 <= rd_c;
                if (r_fc == 3'd3) r_c1 <= rd_c;
            end
            S_TSETUP: begin
                r_cy  <= 1'b0;
                r_t   <= '0;
                r_rem <= '0;
                r_quo <= {rem_w, 16'd0};
                r_dvs <= seg_w;
                r_cnt <= '0;
            end
            S_COEF: begin
                r_h  <= coef3;
                r_hs <= '0;
            end
            S_ACC: begin
                r_h  <= $signed(r_prod[55:16]) + addend;
                r_hs <= r_hs + 1'b1;
            end
            S_SAT: begin
                if (r_cy) r_ry <= h_sat;
                else r_rx <= h_sat;
                r_cy <= 1'b1;
            end
            S_PUT: begin
                if (out_free) begin
                    r_ox   <= r_rx;
                    r_oy   <= r_ry;
                    r_ofin <= last_pos;
                    r_ost  <= r_st;
                    // Next position: its target length numerator and division.
                    r_i    <= r_i + 1'b1;
                    r_itot <= r_itot + 54'(r_lcum);
                    r_rem  <= '0;
                    r_quo  <= 64'(r_itot + 54'(r_lcum));
                    r_dvs  <= 48'(r_n - 1'b1);
                    r_cnt  <= '0;
                end
            end
            default: ;
        endcase
    end

    // The store never holds more points than it has entries.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_kc <= 9'(MAX_POINTS))
        else $error("kept point count beyond store depth");

    // A result that is not the last of its run means the run is still busy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_result) |-> o_stall)
        else $error("point taken while a run is unfinished");

    // The local parameter never exceeds one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COEF) |-> (r_t <= 17'd65536))
        else $error("local parameter above one");

    // The segment found by the search always has a right-hand point.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COEF) |-> (({1'b0, r_j} + 1'b1) < r_k))
        else $error("segment index beyond kept points");

endmodule

### bench/arc_length_catmull_rom_resampler_core_checker.sv
// Checker of the resampler: watches both channels and the APB port, predicts and compares.
`timescale 1ns / 1ps

module arc_length_catmull_rom_resampler_core_checker
    import alcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_last_point,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic               o_final_result,
    input  logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 o_errors,
    output int                 o_outstanding
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               fin;
        logic [1:0]         status;
    } t_sample;

    // Shadow of the gesture store and the register.
    logic signed [31:0]  gx [MAX_POINTS];
    logic signed [31:0]  gy [MAX_POINTS];
    longint unsigned     arc_len [MAX_POINTS];
    int                  npts;
    logic                dropped;
    logic [6:0]          out_count;
    t_sample             samples_due [$];

    // Bitwise square root over 32 steps.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Segment length, with both deltas halved when one no longer fits 31 bits.
    function automatic longint unsigned seg_len(logic signed [31:0] x0, logic signed [31:0] y0,
                                                logic signed [31:0] x1, logic signed [31:0] y1);
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        int              sh;
        dx = longint'(x1) - longint'(x0);
        dy = longint'(y1) - longint'(y0);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sh = (ax > 64'h7FFF_FFFF || ay > 64'h7FFF_FFFF) ? 1 : 0;
        ax = ax >> sh;
        ay = ay >> sh;
        return int_sqrt(ax * ax + ay * ay) << sh;
    endfunction

    // Catmull-Rom in Horner form; shifts of signed values floor towards minus infinity.
    function automatic logic signed [31:0] cr_eval(logic signed [31:0] a, logic signed [31:0] b,
                                                   logic signed [31:0] c, logic signed [31:0] d,
                                                   longint t);
        longint h;
        h = -longint'(a) + 3 * longint'(b) - 3 * longint'(c) + longint'(d);
        h = ((h * t) >>> 16)
            + (2 * longint'(a) - 5 * longint'(b) + 4 * longint'(c) - longint'(d));
        h = ((h * t) >>> 16) + (longint'(c) - longint'(a));
        h = ((h * t) >>> 16) + 2 * longint'(b);
        h = h >>> 1;
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    // Appends one predicted result behind those already waiting.
    task automatic expect_sample(t_sample s);
        samples_due = {samples_due, s};
    endtask

    // Takes one point into the shadow store and, on the last one, queues the whole run.
    task automatic take_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
        int              k;
        int              n;
        int              j;
        int              i0;
        int              i3;
        logic [1:0]      st;
        longint unsigned total;
        longint unsigned target;
        longint unsigned seg;
        longint unsigned rem;
        longint          t;
        t_sample         s;
        if (npts == 0) begin
            gx[0] = x;
            gy[0] = y;
            arc_len[0] = 0;
            npts = 1;
        end else if (x != gx[npts-1] || y != gy[npts-1]) begin
            if (npts >= MAX_POINTS) begin
                dropped = 1'b1;
            end else begin
                arc_len[npts] = arc_len[npts-1] + seg_len(gx[npts-1], gy[npts-1], x, y);
                gx[npts] = x;
                gy[npts] = y;
                npts++;
            end
        end
        if (!last) return;

        k = npts;
        st = dropped ? STATUS_DROPPED : STATUS_OK;
        npts = 0;
        dropped = 1'b0;
        total = (k >= 2) ? arc_len[k-1] : 0;
        if (k < 2 || total == 0) begin
            s = '{x: 0, y: 0, fin: 1'b1, status: STATUS_EMPTY};
            expect_sample(s);
            return;
        end
        n = out_count;
        if (n < OUTPUT_COUNT_MIN) n = OUTPUT_COUNT_MIN;
        if (n > MAX_OUTPUTS) n = MAX_OUTPUTS;
        s = '{x: 0, y: 0, fin: 1'b0, status: st};
        expect_sample(s);
        for (int i = 1; i < n; i++) begin
            target = (longint'(i) * total) / longint'(n - 1);
            j = 0;
            while (j + 1 < k - 1 && arc_len[j+1] <= target) j++;
            seg = arc_len[j+1] - arc_len[j];
            t = 0;
            if (seg != 0) begin
                rem = target - arc_len[j];
                if (rem > seg) rem = seg;
                t = (rem << 16) / seg;
            end
            i0 = (j == 0) ? 0 : j - 1;
            i3 = (j + 2 < k) ? j + 2 : k - 1;
            s.x = cr_eval(gx[i0], gx[j], gx[j+1], gx[i3], t);
            s.y = cr_eval(gy[i0], gy[j], gy[j+1], gy[i3], t);
            s.fin = (i == n - 1);
            s.status = st;
            expect_sample(s);
        end
    endtask

    // Compare each result transfer with the oldest prediction, then take in new points.
    always @(posedge i_clk) begin
        t_sample e;
        if (!i_rst_n) begin
            npts <= 0;
            dropped <= 1'b0;
            out_count <= OUTPUT_COUNT_RESET;
            o_errors <= 0;
            samples_due.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: result with nothing expected: x %h y %h fin %b status %0d",
                             $time, o_out_x, o_out_y, o_final_result, o_status);
                    o_errors <= o_errors + 1;
                end else begin
                    e = samples_due.pop_front();
                    if (e.x !== o_out_x || e.y !== o_out_y || e.fin !== o_final_result
                        || e.status !== o_status) begin
                        $display("%0t: exp x %h y %h fin %b st %0d, got x %h y %h fin %b st %0d",
                                 $time, e.x, e.y, e.fin, e.status,
                                 o_out_x, o_out_y, o_final_result, o_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_COUNT)
                out_count <= pwdata[6:0];
            if (i_valid && !o_stall)
                take_point(i_point_x, i_point_y, i_last_point);
        end
        o_outstanding <= samples_due.size();
    end

endmodule

### bench/arc_length_catmull_rom_resampler_core_test.sv
// Top of the resampler testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module arc_length_catmull_rom_resampler_core_test
    import alcr_pkg::*;
();

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 4000;
    localparam int SETTLE      = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic               i_last_point = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_final_result;
    logic [1:0]         o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 errors;
    int                 outstanding;
    int                 cycles = 0;
    logic               calm = 1'b0;
    int                 hold_asked = 0;
    int                 hold_done = 0;
    int                 hold_left = 0;
    logic signed [31:0] walk_x;
    logic signed [31:0] walk_y;

    arc_length_catmull_rom_resampler_core i_dut (.*);

    arc_length_catmull_rom_resampler_core_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_point_x, .i_point_y, .i_last_point,
        .o_valid, .i_stall, .o_out_x, .o_out_y, .o_final_result, .o_status,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_errors(errors), .o_outstanding(outstanding)
    );

    always #1 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, a calm stretch, and a long hold-off when asked for.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 30);
        end
    end

    // One point transfer, with a random gap in front of it.
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
        if (!calm && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_last_point <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Register write once every expected result is in and the block has settled.
    task automatic write_count(logic [6:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_OUTPUT_COUNT, 2'b00};
        pwdata <= {25'($urandom_range(32'h1FF_FFFF)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random gesture: a walk of small steps, with duplicates, or points spread over the range.
    task automatic send_gesture(int len, bit wide);
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        walk_x = $urandom;
        walk_y = $urandom;
        for (int i = 0; i < len; i++) begin
            if (wide) begin
                sx = $urandom;
                sy = $urandom;
            end else if ($urandom_range(99) < 10) begin
                sx = walk_x;
                sy = walk_y;
            end else begin
                sx = walk_x + $signed($urandom_range(1 << 21)) - (1 << 20);
                sy = walk_y + $signed($urandom_range(1 << 21)) - (1 << 20);
            end
            walk_x = sx;
            walk_y = sy;
            send_point(sx, sy, i == len - 1);
        end
    endtask

    initial begin
        int g;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a lone point, repeated points only, and a last point that duplicates.
        send_point(32'sd5 << 16, -(32'sd3 << 16), 1'b1);
        send_point(32'sh1234_5678, 32'sh0000_0001, 1'b0);
        send_point(32'sh1234_5678, 32'sh0000_0001, 1'b0);
        send_point(32'sh1234_5678, 32'sh0000_0001, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(32'sd10 << 16, 0, 1'b0);
        send_point(32'sd10 << 16, 0, 1'b1);
        // Extremes of the coordinates: deltas beyond 31 bits take the halved root.
        write_count(7'd0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        write_count(7'd127);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        write_count(7'd1);
        send_point(0, 0, 1'b0);
        send_point(32'sd1, 32'sd1, 1'b1);
        write_count(7'd64);
        send_point(0, 0, 1'b0);
        send_point(32'sd3 << 16, 32'sd4 << 16, 1'b0);
        send_point(32'sd7 << 16, 32'sd4 << 16, 1'b1);

        // Store overflow: more distinct points than the store holds, then a last point
        // that repeats the one before it.
        write_count(7'd5);
        walk_x = $urandom;
        walk_y = $urandom;
        for (int i = 0; i < 258; i++) begin
            walk_x = walk_x + $signed($urandom_range(1 << 21, 1 << 20));
            walk_y = walk_y + $signed($urandom_range(1 << 21)) - (1 << 20);
            send_point(walk_x, walk_y, 1'b0);
        end
        send_point(walk_x, walk_y, 1'b1);

        // Random gestures; the register changes between some of them.
        for (g = 0; g < 8; g++) begin
            if (g % 3 == 0) write_count(7'($urandom_range(127)));
            calm = (g >= 3 && g < 5);
            if (g == 6) hold_asked++;
            case ($urandom_range(9))
                0:       send_gesture($urandom_range(1, 2), 1'b0);
                1:       send_gesture($urandom_range(2, 8), 1'b1);
                default: send_gesture($urandom_range(3, 10), 1'b0);
            endcase
        end
        write_count(7'd2);
        send_gesture(6, 1'b0);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
